@@ design/ghh_pkg.sv @@
package ghh_pkg;

  // field widths
  localparam int RateW  = 28;
  localparam int TgtW   = 9;
  localparam int DrvW   = 16;
  localparam int HeadW  = 25;   // wrapped heading, +-180 deg in Q16.16
  localparam int RelW   = 26;   // heading minus origin, +-360 deg
  localparam int WrapW  = 29;   // heading plus one step before wrapping
  localparam int StepW  = 28;   // magnitude of one heading step
  localparam int IntW   = 32;
  localparam int IsumW  = 33;
  localparam int PwmW   = 34;
  localparam int DsumW  = 35;
  localparam int MulW   = 32;
  localparam int ProdW  = 2 * MulW;
  localparam int PrdHW  = 52;   // rate magnitude times tick period
  localparam int FracW  = 24;   // tick period fraction bits
  localparam int QW     = 16;   // Q16.16 fraction bits

  localparam int InDataW  = 72;
  localparam int InUserW  = 1;
  localparam int OutDataW = 64;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic signed [WrapW-1:0] Deg180 = WrapW'(180 * 65536);
  localparam logic signed [WrapW-1:0] Deg360 = WrapW'(360 * 65536);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegPropGain   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegIntegGain  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegRateGain   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegIntegLimit = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegDriveLimit = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegSettleThr  = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] RegSettleTks  = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] RegTickPeriod = CfgIdxW'(7);

  // register reset values
  localparam logic [31:0] RstPropGain   = 32'd4194304;
  localparam logic [31:0] RstIntegGain  = 32'd7209;
  localparam logic [31:0] RstRateGain   = 32'd45875;
  localparam logic [30:0] RstIntegLimit = 31'd131072000;
  localparam logic [14:0] RstDriveLimit = 15'd2600;
  localparam logic [30:0] RstSettleThr  = 31'd131072;
  localparam logic [7:0]  RstSettleTks  = 8'd20;
  localparam logic [23:0] RstTickPeriod = 24'd83886;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_HEAD,
    ST_WRAP_H,
    ST_SETTLE,
    ST_ACT,
    ST_WRAP_A,
    ST_WRAP_E,
    ST_INTEG,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM,
    ST_DRIVE,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MSEL_STEP,
    MSEL_P,
    MSEL_I,
    MSEL_D
  } mul_sel_e;

  typedef struct packed {
    logic in_valid;
    logic wrap_done;
    logic lock_now;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic     in_ready;
    logic     out_load;
    mul_sel_e mul_sel;
  } ctrl_t;

endpackage

@@ design/ghh_mul.sv @@
module ghh_mul (
  input  logic                      clk_i,
  input  logic [ghh_pkg::MulW-1:0]  a_i,
  input  logic [ghh_pkg::MulW-1:0]  b_i,
  output logic [ghh_pkg::ProdW-1:0] p_o
);
  import ghh_pkg::*;

  logic [ProdW-1:0] p_q;

  // unsigned product, registered
  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ design/ghh_seq.sv @@
module ghh_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ghh_pkg::status_t status_i,
  output ghh_pkg::state_e  state_o,
  output ghh_pkg::ctrl_t   ctrl_o
);
  import ghh_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (status_i.in_valid) state_d = ST_STEP;
      ST_STEP:   state_d = ST_HEAD;
      ST_HEAD:   state_d = ST_WRAP_H;
      ST_WRAP_H: if (status_i.wrap_done) state_d = ST_SETTLE;
      ST_SETTLE: state_d = status_i.lock_now ? ST_ACT : ST_OUT;
      ST_ACT:    state_d = ST_WRAP_A;
      ST_WRAP_A: if (status_i.wrap_done) state_d = ST_WRAP_E;
      ST_WRAP_E: if (status_i.wrap_done) state_d = ST_INTEG;
      ST_INTEG:  state_d = ST_MUL_I;
      ST_MUL_I:  state_d = ST_MUL_D;
      ST_MUL_D:  state_d = ST_SUM;
      ST_SUM:    state_d = ST_DRIVE;
      ST_DRIVE:  state_d = ST_OUT;
      ST_OUT:    if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.in_ready = (state_q == ST_IDLE);
    ctrl_o.out_load = (state_q == ST_OUT) && status_i.out_free;
    case (state_q)
      ST_INTEG: ctrl_o.mul_sel = MSEL_P;
      ST_MUL_I: ctrl_o.mul_sel = MSEL_I;
      ST_MUL_D: ctrl_o.mul_sel = MSEL_D;
      default:  ctrl_o.mul_sel = MSEL_STEP;
    endcase
  end

  assign state_o = state_q;

endmodule

@@ design/gyro_heading_hold_pid.sv @@
// Gyro heading-hold PID. One transaction on the slave stream is one control
// tick: the yaw rate is integrated into a heading kept within +-180 deg, the
// block waits for settle_ticks stable ticks before capturing the zero heading
// (lock_event pulses on that tick), and once locked it adds a PID correction to
// the left drive and subtracts it from the right, both saturated to
// drive_limit. Before lock the base drives pass through. While unlocked a tick
// runs the heading step multiply, the heading add and wrap and the settle check
// before the output; once locked (the lock tick included) it also forms and
// wraps the actual heading, subtracts the target, wraps the error, updates the
// integral, runs the P, I and D multiplies, sums them and saturates the drives.
// Each 360 deg wrap adds a wrap step. One multiply runs per cycle on a single
// shared 32x32 multiplier and one 360 deg add/compare per cycle.
// The slave side is not ready while a tick is worked on; the result sits in
// an output register, so the next tick is taken as soon as the result is
// loaded, and a tick only waits when the previous result is still held by
// the master side. Config writes are taken every cycle and must only happen
// while the block is idle.
module gyro_heading_hold_pid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // yaw_rate[27:0], target_heading[36:28], left_base[52:37], right_base[68:53]
  input  logic [ghh_pkg::InDataW-1:0]   s_axis_tdata,
  // restart[0]
  input  logic [ghh_pkg::InUserW-1:0]   s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // left_drive[15:0], right_drive[31:16], locked[32], lock_event[33],
  // relative_heading[59:34]
  output logic [ghh_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ghh_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ghh_pkg::CfgDataW-1:0]  cfg_data_i
);
  import ghh_pkg::*;

  // ---------------------------------------------------------------- config
  logic [31:0] prop_gain_q, integ_gain_q, rate_gain_q;
  logic [30:0] integ_limit_q, settle_thr_q;
  logic [14:0] drive_limit_q;
  logic [7:0]  settle_ticks_q;
  logic [23:0] tick_period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= RstPropGain;
      integ_gain_q   <= RstIntegGain;
      rate_gain_q    <= RstRateGain;
      integ_limit_q  <= RstIntegLimit;
      drive_limit_q  <= RstDriveLimit;
      settle_thr_q   <= RstSettleThr;
      settle_ticks_q <= RstSettleTks;
      tick_period_q  <= RstTickPeriod;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPropGain:   prop_gain_q    <= cfg_data_i;
        RegIntegGain:  integ_gain_q   <= cfg_data_i;
        RegRateGain:   rate_gain_q    <= cfg_data_i;
        RegIntegLimit: integ_limit_q  <= cfg_data_i[30:0];
        RegDriveLimit: drive_limit_q  <= cfg_data_i[14:0];
        RegSettleThr:  settle_thr_q   <= cfg_data_i[30:0];
        RegSettleTks:  settle_ticks_q <= cfg_data_i[7:0];
        RegTickPeriod: tick_period_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- sequencer
  state_e  state;
  ctrl_t   ctrl;
  status_t status;
  logic    in_accept;

  ghh_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .state_o  (state),
    .ctrl_o   (ctrl)
  );

  assign s_axis_tready = ctrl.in_ready;
  assign in_accept     = s_axis_tvalid && ctrl.in_ready;

  // ---------------------------------------------------------- tick operands
  logic signed [RateW-1:0] rate_q;
  logic signed [TgtW-1:0]  target_q;
  logic signed [DrvW-1:0]  left_q, right_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rate_q   <= s_axis_tdata[27:0];
      target_q <= s_axis_tdata[36:28];
      left_q   <= s_axis_tdata[52:37];
      right_q  <= s_axis_tdata[68:53];
    end
  end

  // ------------------------------------------------------------ run state
  logic signed [HeadW-1:0] heading_q, origin_q, prev_err_q;
  logic signed [IntW-1:0]  integ_q;
  logic signed [RateW-1:0] prev_rate_q;
  logic                    lock_q, event_q;
  logic [7:0]              cnt_q;

  // ------------------------------------------------------ shared multiplier
  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] mul_p;
  logic [RateW-1:0] rate_mag;
  logic [HeadW-1:0] err_mag;
  logic [IntW-1:0]  integ_mag;
  logic signed [HeadW-1:0] err_q;

  assign rate_mag  = rate_q[RateW-1] ? RateW'(-rate_q) : RateW'(rate_q);
  assign err_mag   = err_q[HeadW-1] ? HeadW'(-err_q) : HeadW'(err_q);
  assign integ_mag = integ_q[IntW-1] ? IntW'(-integ_q) : IntW'(integ_q);

  always_comb begin
    case (ctrl.mul_sel)
      MSEL_P: begin
        mul_a = MulW'(err_mag);
        mul_b = prop_gain_q;
      end
      MSEL_I: begin
        mul_a = integ_mag;
        mul_b = integ_gain_q;
      end
      MSEL_D: begin
        mul_a = MulW'(rate_mag);
        mul_b = rate_gain_q;
      end
      default: begin
        mul_a = MulW'(rate_mag);
        mul_b = MulW'(tick_period_q);
      end
    endcase
  end

  ghh_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // gain term: product high word, sign of the operand applied (toward zero)
  logic [MulW-1:0]        term_mag;
  logic signed [PwmW-1:0] term_pos, term_neg;
  assign term_mag = mul_p[ProdW-1:MulW];
  assign term_pos = $signed({{(PwmW-MulW){1'b0}}, term_mag});
  assign term_neg = -term_pos;

  // heading step: floor(rate * period / 2^24) from the magnitude product
  logic [PrdHW-1:0]        prod_h, prod_rnd;
  logic [StepW-1:0]        step_mag;
  logic signed [WrapW-1:0] step, head_sum;

  assign prod_h   = mul_p[PrdHW-1:0];
  assign prod_rnd = prod_h + PrdHW'(24'hFFFFFF);
  assign step_mag = rate_q[RateW-1] ? prod_rnd[FracW+StepW-1:FracW]
                                    : prod_h[FracW+StepW-1:FracW];
  assign step     = rate_q[RateW-1] ? -$signed({1'b0, step_mag})
                                    : $signed({1'b0, step_mag});
  assign head_sum = WrapW'(heading_q) + step;

  // ---------------------------------------------------- 360 deg wrap unit
  logic signed [WrapW-1:0] wrap_q, wrap_nx;
  logic                    wrap_hi, wrap_lo;
  logic signed [WrapW-1:0] tgt_fix;

  assign wrap_hi = wrap_q > Deg180;
  assign wrap_lo = wrap_q < -Deg180;
  assign wrap_nx = wrap_hi ? wrap_q - Deg360 : wrap_q + Deg360;
  assign tgt_fix = $signed({{(WrapW-TgtW-QW){target_q[TgtW-1]}}, target_q, {QW{1'b0}}});

  // ------------------------------------------------------- settle / lock
  logic signed [RateW:0] rate_diff;
  logic [RateW:0]        diff_mag;
  logic                  stable, capture;
  logic [7:0]            cnt_inc;

  assign rate_diff = (RateW+1)'(rate_q) - (RateW+1)'(prev_rate_q);
  assign diff_mag  = rate_diff[RateW] ? (RateW+1)'(-rate_diff) : (RateW+1)'(rate_diff);
  assign stable    = {2'b00, diff_mag} < settle_thr_q;
  assign cnt_inc   = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
  assign capture   = !lock_q && stable && (cnt_inc >= settle_ticks_q);

  // --------------------------------------------------- integral and clamp
  logic signed [IsumW-1:0] isum, ilim, isat;
  logic                    sign_flip;

  assign isum = IsumW'(integ_q) + IsumW'(err_q);
  assign ilim = $signed({2'b00, integ_limit_q});
  assign isat = (isum > ilim) ? ilim : ((isum < -ilim) ? -ilim : isum);
  assign sign_flip = ((err_q > 0) && (prev_err_q < 0)) ||
                     ((err_q < 0) && (prev_err_q > 0));

  // --------------------------------------------------------- drive stage
  logic signed [PwmW-1:0]  pwm_q;
  logic signed [DsumW-1:0] lsum, rsum, dlim, lsat, rsat;
  logic signed [DrvW-1:0]  drv_left_q, drv_right_q;

  assign lsum = DsumW'(left_q) + DsumW'(pwm_q);
  assign rsum = DsumW'(right_q) - DsumW'(pwm_q);
  assign dlim = $signed({{(DsumW-15){1'b0}}, drive_limit_q});
  assign lsat = (lsum > dlim) ? dlim : ((lsum < -dlim) ? -dlim : lsum);
  assign rsat = (rsum > dlim) ? dlim : ((rsum < -dlim) ? -dlim : rsum);

  // payload datapath
  always_ff @(posedge clk_i) begin
    case (state)
      ST_HEAD:   wrap_q <= head_sum;
      ST_WRAP_H: if (wrap_hi || wrap_lo) wrap_q <= wrap_nx;
      ST_ACT:    wrap_q <= WrapW'(heading_q) - WrapW'(origin_q);
      ST_WRAP_A: wrap_q <= (wrap_hi || wrap_lo) ? wrap_nx : wrap_q - tgt_fix;
      ST_WRAP_E: begin
        if (wrap_hi || wrap_lo) begin
          wrap_q <= wrap_nx;
        end else begin
          err_q <= wrap_q[HeadW-1:0];
        end
      end
      ST_SETTLE: begin
        if (!(lock_q || capture)) begin
          drv_left_q  <= left_q;
          drv_right_q <= right_q;
        end
      end
      ST_MUL_I:  pwm_q <= err_q[HeadW-1] ? term_neg : term_pos;
      ST_MUL_D:  pwm_q <= pwm_q + (integ_q[IntW-1] ? term_neg : term_pos);
      ST_SUM:    pwm_q <= pwm_q - (rate_q[RateW-1] ? term_neg : term_pos);
      ST_DRIVE: begin
        drv_left_q  <= lsat[DrvW-1:0];
        drv_right_q <= rsat[DrvW-1:0];
      end
      default: ;
    endcase
  end

  // run state, cleared by reset; restart clears all but the last error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q   <= '0;
      origin_q    <= '0;
      integ_q     <= '0;
      lock_q      <= 1'b0;
      cnt_q       <= '0;
      prev_rate_q <= '0;
      prev_err_q  <= '0;
      event_q     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            event_q <= 1'b0;
            if (s_axis_tuser[0]) begin
              heading_q   <= '0;
              origin_q    <= '0;
              integ_q     <= '0;
              lock_q      <= 1'b0;
              cnt_q       <= '0;
              prev_rate_q <= '0;
            end
          end
        end
        ST_WRAP_H: begin
          if (!(wrap_hi || wrap_lo)) heading_q <= wrap_q[HeadW-1:0];
        end
        ST_SETTLE: begin
          if (!lock_q) begin
            prev_rate_q <= rate_q;
            cnt_q       <= stable ? cnt_inc : 8'd0;
            if (capture) begin
              origin_q <= heading_q;
              integ_q  <= '0;
              lock_q   <= 1'b1;
              event_q  <= 1'b1;
            end
          end
        end
        ST_INTEG: begin
          integ_q    <= sign_flip ? '0 : isat[IntW-1:0];
          prev_err_q <= err_q;
        end
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------------- output reg
  logic                   m_valid_q;
  logic signed [DrvW-1:0] out_left_q, out_right_q;
  logic                   out_lock_q, out_event_q;
  logic signed [RelW-1:0] out_rel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_left_q  <= drv_left_q;
      out_right_q <= drv_right_q;
      out_lock_q  <= lock_q;
      out_event_q <= event_q;
      out_rel_q   <= RelW'(heading_q) - RelW'(origin_q);
    end
  end

  assign status.in_valid  = s_axis_tvalid;
  assign status.wrap_done = !(wrap_hi || wrap_lo);
  assign status.lock_now  = lock_q || capture;
  assign status.out_free  = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW-RelW-2-2*DrvW){1'b0}}, out_rel_q, out_event_q,
                          out_lock_q, out_right_q, out_left_q};

endmodule
